### design/msa_pkg.sv
package msa_pkg;

    // Width of one stored word.
    localparam int DATA_W = 32;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP      = 2'd1,
        CMD_PEEK     = 2'd2,
        CMD_IS_EMPTY = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // Decoded outcome of one transaction, carried alongside the memory read.
    typedef struct packed {
        status_t status;
        logic    is_empty;
        logic    rd;
    } item_info_t;

endpackage

### design/msa_ram.sv
module msa_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [AW-1:0]              addr,
    input  logic [msa_pkg::DATA_W-1:0] wdata,
    output logic [msa_pkg::DATA_W-1:0] rdata
);
    import msa_pkg::*;

    logic [DATA_W-1:0] stack_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= stack_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/msa_ctrl.sv
module msa_ctrl #(
    parameter int DEPTH      = 128,
    parameter int MAX_STACKS = 8,
    parameter int AW         = 7,
    parameter int CNT_W      = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [3:0]                 cfg_wdata,
    input  logic                       accept,
    input  logic [1:0]                 command,
    input  logic [2:0]                 stack_index,
    input  logic [msa_pkg::DATA_W-1:0] value,
    output logic                       ram_we,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_addr,
    output logic [msa_pkg::DATA_W-1:0] ram_wdata,
    output msa_pkg::item_info_t        info
);
    import msa_pkg::*;

    localparam int NS_W   = $clog2(MAX_STACKS + 1);
    localparam int TBL_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int FC_N   = (MAX_STACKS < 8) ? MAX_STACKS : 8;
    localparam int IDX_W  = (FC_N > 1) ? $clog2(FC_N) : 1;
    localparam int PROD_W = CNT_W + 3;

    logic [NS_W-1:0]  num_stacks_reg;
    logic [CNT_W-1:0] region_size_reg;
    logic [CNT_W-1:0] fill_cnt_reg [FC_N];

    logic [CNT_W-1:0] size_tbl [MAX_STACKS];
    logic [4:0]       cfg_wide;
    logic [NS_W-1:0]  ns_clamped;
    logic [NS_W-1:0]  ns_minus1;

    logic              idx_ok;
    logic              last_stack;
    logic [IDX_W-1:0]  fidx;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  cnt_next;
    logic [PROD_W-1:0] base_prod;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  top_sum;
    logic              want_we;
    logic              want_re;
    status_t           st;
    logic              rd;

    // Region size for every possible stack count, fixed at elaboration.
    for (genvar i = 0; i < MAX_STACKS; i++)
    begin : g_size
        localparam int SIZE = DEPTH / (i + 1);
        assign size_tbl[i] = CNT_W'(SIZE);
    end

    // Clamp a written stack count into 1..MAX_STACKS.
    always_comb
    begin
        cfg_wide = {1'b0, cfg_wdata};
        if (cfg_wide == 5'd0)
        begin
            ns_clamped = NS_W'(1);
        end
        else if (cfg_wide > 5'(MAX_STACKS))
        begin
            ns_clamped = NS_W'(MAX_STACKS);
        end
        else
        begin
            ns_clamped = NS_W'(cfg_wide);
        end
        ns_minus1 = ns_clamped - NS_W'(1);
    end

    // Region geometry and fill count of the addressed stack.
    always_comb
    begin
        idx_ok     = 5'(stack_index) < 5'(num_stacks_reg);
        last_stack = (5'(stack_index) + 5'd1) == 5'(num_stacks_reg);
        fidx       = stack_index[IDX_W-1:0];
        cnt        = fill_cnt_reg[fidx];
        base_prod  = PROD_W'(stack_index) * PROD_W'(region_size_reg);
        base       = base_prod[CNT_W-1:0];
        limit      = last_stack ? (CNT_W'(DEPTH) - base) : region_size_reg;
        top_sum    = base + cnt;
    end

    // Command decode: status, memory access and new fill count.
    always_comb
    begin
        st       = ST_OK;
        rd       = 1'b0;
        want_we  = 1'b0;
        want_re  = 1'b0;
        cnt_next = cnt;
        ram_addr = top_sum[AW-1:0];
        case (cmd_t'(command))
            CMD_PUSH:
            begin
                if (cnt >= limit)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    want_we  = 1'b1;
                    cnt_next = cnt + CNT_W'(1);
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                ram_addr = AW'(top_sum - CNT_W'(1));
                if (cnt == '0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    want_re = 1'b1;
                    rd      = 1'b1;
                    if (cmd_t'(command) == CMD_POP)
                    begin
                        cnt_next = cnt - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        if (!idx_ok)
        begin
            st      = ST_BADIDX;
            rd      = 1'b0;
            want_we = 1'b0;
            want_re = 1'b0;
        end
    end

    assign ram_we        = accept && want_we;
    assign ram_re        = accept && want_re;
    assign ram_wdata     = value;
    assign info.status   = st;
    assign info.rd       = rd;
    assign info.is_empty = idx_ok && (cnt_next == '0);

    // Configuration and fill counts; a configuration write empties every stack.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_stacks_reg  <= NS_W'(1);
            region_size_reg <= CNT_W'(DEPTH);
            for (int i = 0; i < FC_N; i++)
            begin
                fill_cnt_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            num_stacks_reg  <= ns_clamped;
            region_size_reg <= size_tbl[ns_minus1[TBL_W-1:0]];
            for (int i = 0; i < FC_N; i++)
            begin
                fill_cnt_reg[i] <= '0;
            end
        end
        else if (accept && idx_ok)
        begin
            fill_cnt_reg[fidx] <= cnt_next;
        end
    end

endmodule

### design/multi_stack_shared_array.sv
// Several LIFO stacks sharing one single-port memory of DEPTH words.
// The memory is split into num_stacks fixed regions; the last stack also
// owns the leftover words up to the end of the memory.
// Input channel (in_valid/in_ready): command, stack_index and value. Each
// input transaction yields exactly one output transaction (out_valid/
// out_ready) with data, status and is_empty.
// Configuration channel (cfg_valid/cfg_ready): writes num_stacks, clamped
// to 1..MAX_STACKS, and empties every stack in the same cycle. It is
// always ready. The user must write it only while no transaction is in
// flight; the block does not check it. Accepted transactions pass the read
// stage, then the output register. Throughput: one transaction per cycle
// unless the receiver stalls, set by the single memory port, doing one
// read or one write each cycle; fill counts are registers updated at
// acceptance. When the receiver stalls, one result waits in the output
// register and one more in the read stage; in_ready then drops until the
// output moves. Reset empties every stack and sets num_stacks to 1. Memory
// contents are not cleared; a word is read only after it has been pushed.
module multi_stack_shared_array #(
    parameter int DEPTH      = 128,
    parameter int MAX_STACKS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [3:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [2:0]                 stack_index,
    input  logic [msa_pkg::DATA_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [msa_pkg::DATA_W-1:0] data,
    output logic [1:0]                 status,
    output logic                       is_empty
);
    import msa_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic              cfg_we;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    item_info_t        info;

    logic              s1_valid_reg;
    item_info_t        s1_info_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] data_reg;
    status_t           status_reg;
    logic              is_empty_reg;

    logic              out_free;
    logic              s1_move;

    // Handshakes: the read stage moves when the output register is free.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign accept    = in_valid && in_ready;

    msa_ctrl #(
        .DEPTH      (DEPTH),
        .MAX_STACKS (MAX_STACKS),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_data),
        .accept      (accept),
        .command     (command),
        .stack_index (stack_index),
        .value       (value),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .info        (info)
    );

    msa_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control state of the read stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the read stage and the output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (s1_move)
        begin
            data_reg     <= s1_info_reg.rd ? ram_rdata : '0;
            status_reg   <= s1_info_reg.status;
            is_empty_reg <= s1_info_reg.is_empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign is_empty  = is_empty_reg;

    // The memory is only touched by an accepted transaction.
    a_ram_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we || ram_re) |-> accept)
        else $error("memory access without an accepted transaction");

    // A full pipeline behind a stalled receiver takes no new transaction.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while the pipeline is stalled");

    // A read issued now is marked to be used by the read stage next cycle.
    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (s1_valid_reg && s1_info_reg.rd))
        else $error("memory read lost by the read stage");

    // Failed operations return zero data (so do non-reading ones, not checked here).
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (data_reg == '0))
        else $error("nonzero data with an error status");

endmodule

### tb/multi_stack_shared_array_tb.sv
module multi_stack_shared_array_tb;

    import msa_pkg::*;

    localparam int DEPTH       = 128;
    localparam int MAX_STACKS  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    // One predicted result transaction.
    typedef struct {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic              is_empty;
    } stack_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [3:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        command;
    logic [2:0]        stack_index;
    logic [DATA_W-1:0] value;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic              is_empty;

    // Shadow copy of the stack state.
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int unsigned       shadow_fill [MAX_STACKS];
    int unsigned       shadow_stacks;

    stack_result_t     pending_results [$];
    int                err_count;
    int                n_checked;
    int                cycle_count;
    int                rx_hold;
    bit                idle_on;

    multi_stack_shared_array #(
        .DEPTH      (DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .stack_index (stack_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data        (data),
        .status      (status),
        .is_empty    (is_empty)
    );

    // Clock with a period of 10 time units.
    always #5 clk = ~clk;

    // Gap length: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    // Apply a num_stacks write to the shadow state, with clamping.
    function automatic void shadow_configure(logic [3:0] v);
        if (v == 0)
            shadow_stacks = 1;
        else if (v > MAX_STACKS)
            shadow_stacks = MAX_STACKS;
        else
            shadow_stacks = 32'(v);
        foreach (shadow_fill[k])
            shadow_fill[k] = 0;
    endfunction

    // Work out the result of one operation and update the shadow state.
    function automatic stack_result_t predict_stack_op(cmd_t cmd, logic [2:0] idx,
                                                       logic [DATA_W-1:0] val);
        stack_result_t r;
        int unsigned   region;
        int unsigned   base;
        int unsigned   limit;
        int unsigned   cnt;
        r.data     = '0;
        r.status   = ST_OK;
        r.is_empty = 1'b0;
        if (idx >= shadow_stacks)
        begin
            r.status = ST_BADIDX;
        end
        else
        begin
            region = DEPTH / shadow_stacks;
            base   = idx * region;
            limit  = (idx == shadow_stacks - 1) ? DEPTH - base : region;
            cnt    = shadow_fill[idx];
            case (cmd)
                CMD_PUSH:
                begin
                    if (cnt >= limit)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        shadow_mem[base + cnt] = val;
                        cnt++;
                    end
                end
                CMD_POP, CMD_PEEK:
                begin
                    if (cnt == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.data = shadow_mem[base + cnt - 1];
                        if (cmd == CMD_POP)
                            cnt--;
                    end
                end
                default: ;
            endcase
            shadow_fill[idx] = cnt;
            r.is_empty       = (cnt == 0);
        end
        return r;
    endfunction

    // Send one input transaction and record its predicted result.
    task automatic send_item(cmd_t cmd, logic [2:0] idx, logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command     <= cmd;
        stack_index <= idx;
        value       <= val;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_stack_op(cmd, idx, val));
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold off until every predicted result has come back.
    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write num_stacks while the block is idle.
    task automatic write_num_stacks(logic [3:0] v);
        go_idle();
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_configure(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Every operation on a single stack, extreme words and a bad index.
    task automatic test_basic_ops();
        write_num_stacks(4'd0);
        send_item(CMD_IS_EMPTY, 3'd0, '0);
        send_item(CMD_POP,      3'd0, '0);
        send_item(CMD_PEEK,     3'd0, '1);
        send_item(CMD_PUSH,     3'd0, 32'h7FFF_FFFF);
        send_item(CMD_PUSH,     3'd0, 32'h8000_0000);
        send_item(CMD_PUSH,     3'd0, 32'hFFFF_FFFF);
        send_item(CMD_PEEK,     3'd0, '0);
        send_item(CMD_POP,      3'd0, '0);
        send_item(CMD_POP,      3'd0, '0);
        send_item(CMD_POP,      3'd0, '0);
        send_item(CMD_IS_EMPTY, 3'd0, '0);
        send_item(CMD_PUSH,     3'd5, 32'h1234_5678);
        send_item(CMD_PEEK,     3'd7, '0);
    endtask

    // Fill the last region of eight to overflow; a large write clamps.
    task automatic test_region_full();
        write_num_stacks(4'd15);
        for (int i = 0; i < 16; i++)
            send_item(CMD_PUSH, 3'd7, $urandom);
        send_item(CMD_PUSH, 3'd7, 32'hDEAD_BEEF);
        send_item(CMD_POP,  3'd7, '0);
        send_item(CMD_PEEK, 3'd6, '0);
    endtask

    // Random traffic with a hot stack and a changing push ratio.
    task automatic test_random_traffic(logic [3:0] cfg_value, int n_items);
        cmd_t              cmd;
        logic [2:0]        idx;
        logic [DATA_W-1:0] val;
        int                hot;
        int                hot_left;
        int                push_pct;
        int                r;
        write_num_stacks(cfg_value);
        hot_left = 0;
        hot      = 0;
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (hot_left == 0)
            begin
                hot      = $urandom_range(0, shadow_stacks - 1);
                hot_left = $urandom_range(10, 40);
                push_pct = $urandom_range(20, 90);
            end
            hot_left--;
            idx = ($urandom_range(0, 9) < 7) ? 3'(hot) : 3'($urandom_range(0, 7));
            r   = $urandom_range(0, 99);
            if (r < push_pct)
            begin
                cmd = CMD_PUSH;
            end
            else
            begin
                r = $urandom_range(0, 5);
                if (r < 3)
                    cmd = CMD_POP;
                else if (r < 5)
                    cmd = CMD_PEEK;
                else
                    cmd = CMD_IS_EMPTY;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: val = 32'h0000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = 32'h8000_0000;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end
            else
            begin
                val = $urandom;
            end
            // Now and then the sender waits for the pipeline to empty.
            if ($urandom_range(0, 79) == 0)
            begin
                go_idle();
                wait_for_drain();
            end
            send_item(cmd, idx, val);
        end
    endtask

    // Record a failed comparison; only the first few are printed.
    task automatic flag_mismatch(string field, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
        err_count++;
        if (err_count <= 10)
            $display("Mismatch in %s of result %0d: expected %h, got %h",
                     field, n_checked, want, got);
    endtask

    // Check each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("Unexpected result: data %h status %0d is_empty %b",
                             data, status, is_empty);
            end
            else
            begin
                want = pending_results.pop_front();
                if (data !== want.data)
                    flag_mismatch("data", want.data, data);
                if (status !== want.status)
                    flag_mismatch("status", DATA_W'(want.status), DATA_W'(status));
                if (is_empty !== want.is_empty)
                    flag_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty));
            end
            n_checked++;
        end
    end

    // Receiver stalls of random length.
    always @(negedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_hold = pick_gap();
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        logic [3:0] phase_cfg [11];
        phase_cfg   = '{4'd1, 4'd2, 4'd3, 4'd8, 4'd5, 4'd7, 4'd0, 4'd6, 4'd12, 4'd4, 4'd8};
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_PUSH;
        stack_index = '0;
        value       = '0;
        out_ready   = 1'b0;
        err_count   = 0;
        n_checked   = 0;
        cycle_count = 0;
        rx_hold     = 0;
        idle_on     = 1'b1;
        shadow_configure(4'd1);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_region_full();
        foreach (phase_cfg[p])
        begin
            // Some phases run with no idling on either side.
            idle_on = (p % 4 != 2);
            test_random_traffic(phase_cfg[p], 120);
        end
        idle_on = 1'b1;

        go_idle();
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/msa_pkg.sv
design/msa_ram.sv
design/msa_ctrl.sv
design/multi_stack_shared_array.sv
tb/multi_stack_shared_array_tb.sv
